### rtl/byte_budget_lru_cache_macros.svh
// ----------------------------------------------------------------------------
// Byte-budget LRU cache assertion macros
// Shared assertion shorthands for the cache checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_MACROS_SVH

// Same-cycle implication, clocked on aclk and quiet during reset.
`define BLRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and quiet during reset.
`define BLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/blru_pkg.sv
// ----------------------------------------------------------------------------
// Byte-budget LRU cache package
// Sizes, operation codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package blru_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 64;
    localparam int SIZE_W  = 24;
    localparam int TOT_W   = 25;
    localparam int EVC_W   = 7;
    localparam int OP_W    = 2;

    localparam logic [SIZE_W-1:0] CAP_RESET = 24'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic touch;
        logic rd_value;
        logic rd_size;
        logic replace;
        logic insert;
        logic evict_sel;
        logic evict_sub;
        logic clear_all;
        logic get_data;
        logic out_load;
    } blru_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cap_zero;
        logic            hit;
        logic            full;
        logic            over;
        logic            out_busy;
    } blru_stat_t;

endpackage

### rtl/blru_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module blru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/blru_datapath.sv
// ----------------------------------------------------------------------------
// Byte-budget LRU cache datapath
// Slot cells with key compare and recency rank, size and value memories,
// the byte total, the capacity register and the result register.
// ----------------------------------------------------------------------------
module blru_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [blru_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic [blru_pkg::OP_W-1:0]      s_operation,
    input  logic [blru_pkg::KEY_W-1:0]     s_key,
    input  logic [blru_pkg::VAL_W-1:0]     s_value_word,
    input  logic [blru_pkg::SIZE_W-1:0]    s_value_size,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic                           m_hit,
    output logic [blru_pkg::VAL_W-1:0]     m_value_out,
    output logic [blru_pkg::EVC_W-1:0]     m_evicted_count,
    output logic [blru_pkg::SIZE_W-1:0]    m_bytes_in_use,
    input  blru_pkg::blru_cmd_t            cmd,
    output blru_pkg::blru_stat_t           stat
);
    import blru_pkg::*;

    logic [SIZE_W-1:0] cap_reg;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [SIZE_W-1:0] size_reg;

    logic              slot_valid_reg [ENTRIES];
    logic [KEY_W-1:0]  slot_key_reg   [ENTRIES];
    logic [IDX_W-1:0]  slot_rank_reg  [ENTRIES];
    logic [CNT_W-1:0]  count_reg;
    logic [TOT_W-1:0]  used_reg;
    logic [TOT_W-1:0]  used_next;

    logic [IDX_W-1:0]  sel_idx_reg;
    logic              hit_reg;
    logic              get_hit_reg;
    logic [VAL_W-1:0]  value_hold_reg;
    logic [EVC_W-1:0]  evict_cnt_reg;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [EVC_W-1:0]  out_evict_reg;
    logic [SIZE_W-1:0] out_bytes_reg;

    logic              match_any;
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic [IDX_W-1:0]  lru_rank;
    logic [IDX_W-1:0]  sel_rank;

    logic [SIZE_W-1:0] size_rdata;
    logic [VAL_W-1:0]  value_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  size_raddr;

    assign lru_rank = IDX_W'(count_reg - CNT_W'(1));
    assign sel_rank = slot_rank_reg[sel_idx_reg];

    // Per-slot key match, lowest free slot and least recent slot.
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        lru_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid_reg[i] && slot_key_reg[i] == key_reg) begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
            if (slot_valid_reg[i] && slot_rank_reg[i] == lru_rank) begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    // Memory port steering.
    assign ram_we     = cmd.replace || cmd.insert;
    assign ram_waddr  = cmd.insert ? free_idx : sel_idx_reg;
    assign size_raddr = cmd.evict_sel ? lru_idx : sel_idx_reg;

    blru_ram #(.WIDTH(SIZE_W), .DEPTH(ENTRIES)) u_size_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (size_reg),
        .re    (cmd.rd_size || cmd.evict_sel),
        .raddr (size_raddr),
        .rdata (size_rdata)
    );

    blru_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .re    (cmd.rd_value),
        .raddr (sel_idx_reg),
        .rdata (value_rdata)
    );

    // Byte total update; all arithmetic wraps at the total width.
    always_comb begin
        used_next = used_reg;
        if (cmd.clear_all) begin
            used_next = '0;
        end else if (cmd.replace) begin
            used_next = used_reg - TOT_W'(size_rdata) + TOT_W'(size_reg);
        end else if (cmd.insert) begin
            used_next = used_reg + TOT_W'(size_reg);
        end else if (cmd.evict_sub) begin
            used_next = used_reg - TOT_W'(size_rdata);
        end
    end

    // Status toward the controller.
    assign stat.op       = op_reg;
    assign stat.cap_zero = (cap_reg == '0);
    assign stat.hit      = hit_reg;
    assign stat.full     = (count_reg == CNT_W'(ENTRIES));
    assign stat.over     = (used_reg > TOT_W'(cap_reg)) && (count_reg != '0);
    assign stat.out_busy = out_valid_reg && !m_ready;

    // Capacity register, entry count, byte total and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            used_reg <= used_next;
            if (cmd.clear_all) begin
                count_reg <= '0;
            end else if (cmd.insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.evict_sel) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the request and the result.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_operation;
            key_reg        <= s_key;
            val_reg        <= s_value_word;
            size_reg       <= s_value_size;
            get_hit_reg    <= 1'b0;
            value_hold_reg <= '0;
            evict_cnt_reg  <= '0;
        end
        if (cmd.lookup) begin
            hit_reg     <= match_any;
            sel_idx_reg <= match_idx;
        end
        if (cmd.get_data) begin
            get_hit_reg    <= 1'b1;
            value_hold_reg <= value_rdata;
        end
        if (cmd.evict_sel && evict_cnt_reg != '1) begin
            evict_cnt_reg <= evict_cnt_reg + EVC_W'(1);
        end
        if (cmd.out_load) begin
            out_hit_reg   <= get_hit_reg;
            out_value_reg <= value_hold_reg;
            out_evict_reg <= evict_cnt_reg;
            out_bytes_reg <= used_reg[SIZE_W-1:0];
        end
    end

    // Slot cells: valid bit, key and recency rank.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (!aresetn || cmd.clear_all) begin
                slot_valid_reg[i] <= 1'b0;
            end else if (cmd.insert && free_idx == IDX_W'(i)) begin
                slot_valid_reg[i] <= 1'b1;
            end else if (cmd.evict_sel && lru_idx == IDX_W'(i)) begin
                slot_valid_reg[i] <= 1'b0;
            end
            if (cmd.insert) begin
                if (free_idx == IDX_W'(i)) begin
                    slot_key_reg[i]  <= key_reg;
                    slot_rank_reg[i] <= '0;
                end else if (slot_valid_reg[i]) begin
                    slot_rank_reg[i] <= slot_rank_reg[i] + IDX_W'(1);
                end
            end else if (cmd.touch) begin
                if (sel_idx_reg == IDX_W'(i)) begin
                    slot_rank_reg[i] <= '0;
                end else if (slot_valid_reg[i] && slot_rank_reg[i] < sel_rank) begin
                    slot_rank_reg[i] <= slot_rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = out_hit_reg;
    assign m_value_out     = out_value_reg;
    assign m_evicted_count = out_evict_reg;
    assign m_bytes_in_use  = out_bytes_reg;

endmodule

### rtl/blru_ctrl.sv
// ----------------------------------------------------------------------------
// Byte-budget LRU cache controller
// Sequences lookup, recency update, insert, replace, clear and the eviction loop.
// ----------------------------------------------------------------------------
module blru_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  blru_pkg::blru_stat_t stat,
    output blru_pkg::blru_cmd_t  cmd
);
    import blru_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_LOOKUP    = 10'b0000000010,
        ST_DECIDE    = 10'b0000000100,
        ST_GET_DATA  = 10'b0000001000,
        ST_REPLACE   = 10'b0000010000,
        ST_PRE_SUB   = 10'b0000100000,
        ST_INSERT    = 10'b0001000000,
        ST_EVICT_CHK = 10'b0010000000,
        ST_EVICT_SUB = 10'b0100000000,
        ST_RESP      = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                case (stat.op)
                    OP_GET: begin
                        if (!stat.cap_zero && stat.hit) begin
                            cmd.touch    = 1'b1;
                            cmd.rd_value = 1'b1;
                            state_next   = ST_GET_DATA;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    OP_PUT: begin
                        if (stat.cap_zero) begin
                            state_next = ST_RESP;
                        end else if (stat.hit) begin
                            cmd.rd_size = 1'b1;
                            state_next  = ST_REPLACE;
                        end else if (stat.full) begin
                            cmd.evict_sel = 1'b1;
                            state_next    = ST_PRE_SUB;
                        end else begin
                            state_next = ST_INSERT;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_RESP;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_GET_DATA: begin
                cmd.get_data = 1'b1;
                state_next   = ST_RESP;
            end
            ST_REPLACE: begin
                cmd.replace = 1'b1;
                cmd.touch   = 1'b1;
                state_next  = ST_EVICT_CHK;
            end
            ST_PRE_SUB: begin
                cmd.evict_sub = 1'b1;
                state_next    = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_EVICT_CHK;
            end
            ST_EVICT_CHK: begin
                if (stat.over) begin
                    cmd.evict_sel = 1'b1;
                    state_next    = ST_EVICT_SUB;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_EVICT_SUB: begin
                cmd.evict_sub = 1'b1;
                state_next    = ST_EVICT_CHK;
            end
            ST_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/byte_budget_lru_cache.sv
// ----------------------------------------------------------------------------
// Byte-budget LRU cache
// Keyed cache of 64-bit value handles whose budget is a total of byte sizes.
// ----------------------------------------------------------------------------
// The cache takes one item at a time and accepts the next one once the
// previous item has been placed in the output register. A get looks up the
// key and, on a hit, also reads the value memory; a clear empties every slot.
// A put either inserts a new key, first evicting the least recent entry when
// the cache is full, or replaces an existing one; it then evicts entries one
// by one to meet the byte budget, since each eviction reads the victim's
// size from the size memory before subtracting it. The output register then
// holds the result until it is taken. Capacity writes belong between items.
module byte_budget_lru_cache (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [blru_pkg::SIZE_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [blru_pkg::OP_W-1:0]      s_operation,
    input  logic [blru_pkg::KEY_W-1:0]     s_key,
    input  logic [blru_pkg::VAL_W-1:0]     s_value_word,
    input  logic [blru_pkg::SIZE_W-1:0]    s_value_size,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [blru_pkg::VAL_W-1:0]     m_value_out,
    output logic [blru_pkg::EVC_W-1:0]     m_evicted_count,
    output logic [blru_pkg::SIZE_W-1:0]    m_bytes_in_use
);
    import blru_pkg::*;

    blru_cmd_t  cmd;
    blru_stat_t stat;

    // Sequencer.
    blru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slots, memories and result register.
    blru_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_operation     (s_operation),
        .s_key           (s_key),
        .s_value_word    (s_value_word),
        .s_value_size    (s_value_size),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_hit           (m_hit),
        .m_value_out     (m_value_out),
        .m_evicted_count (m_evicted_count),
        .m_bytes_in_use  (m_bytes_in_use),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

### rtl/blru_checker.sv
// ----------------------------------------------------------------------------
// Byte-budget LRU cache checker
// Port-level assertions, bound to the cache top level.
// ----------------------------------------------------------------------------
`include "byte_budget_lru_cache_macros.svh"

module blru_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_hit,
    input logic [blru_pkg::VAL_W-1:0]  m_value_out,
    input logic [blru_pkg::EVC_W-1:0]  m_evicted_count
);
    import blru_pkg::*;

    // A held result keeps its handle.
    `BLRU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_value_out), "result changed while stalled")

    // One item at a time: an accepted item closes the input until it is done.
    `BLRU_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "input reopened right after accept")

    // A miss or a non-get returns a zero handle.
    `BLRU_ASSERT_NOW(a_miss_zero, m_valid && !m_hit, m_value_out == '0, "nonzero handle without a hit")

    // A get hit never evicts.
    `BLRU_ASSERT_NOW(a_hit_no_evict, m_valid && m_hit, m_evicted_count == '0, "eviction reported on a hit")

endmodule

bind byte_budget_lru_cache blru_checker u_blru_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit           (m_hit),
    .m_value_out     (m_value_out),
    .m_evicted_count (m_evicted_count)
);
